// File: rtl/rrip_pkg.sv
package rrip_pkg;

    localparam int DEF_NUM_SETS    = 2048;
    localparam int DEF_NUM_WAYS    = 16;
    localparam int DEF_LEADER_SETS = 64;

    localparam int SET_IN_W = 11;
    localparam int MASK_W   = 16;
    localparam int WAY_W    = 4;
    localparam int CHANCE_W = 5;
    localparam int DUEL_W   = 10;
    localparam int RRPV_W   = 2;

    // Wide enough for a set index and for the set count shifted up by two.
    localparam int REM_W = 20;

    localparam logic [RRPV_W-1:0] RRPV_ZERO = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;

    localparam logic [DUEL_W-1:0] DUEL_ZERO = 10'd0;
    localparam logic [DUEL_W-1:0] DUEL_MID  = 10'd512;
    localparam logic [DUEL_W-1:0] DUEL_TOP  = 10'd1023;

    localparam logic REQ_VICTIM = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY
    } rrip_state_t;

    typedef struct packed {
        logic              req_type;
        logic [MASK_W-1:0] mask;
        logic [WAY_W-1:0]  way;
        logic              is_hit;
        logic              chance_zero;
        logic              first;
        logic              second;
    } rrip_req_t;

endpackage

// File: rtl/rrip_row_mem.sv
module rrip_row_mem #(
    parameter int DEPTH  = rrip_pkg::DEF_NUM_SETS,
    parameter int ROW_W  = rrip_pkg::DEF_NUM_WAYS * rrip_pkg::RRPV_W,
    parameter int ADDR_W = $clog2(rrip_pkg::DEF_NUM_SETS)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [ROW_W-1:0]  wdata,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (en)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: rtl/rrip_row_logic.sv
module rrip_row_logic #(
    parameter int NUM_WAYS = rrip_pkg::DEF_NUM_WAYS
) (
    input  rrip_pkg::rrip_req_t                           req,
    input  logic [NUM_WAYS*rrip_pkg::RRPV_W-1:0]          row_in,
    input  logic [rrip_pkg::DUEL_W-1:0]                   duel_in,
    output logic [NUM_WAYS*rrip_pkg::RRPV_W-1:0]          row_out,
    output logic [rrip_pkg::WAY_W-1:0]                    victim,
    output logic [rrip_pkg::DUEL_W-1:0]                   duel_out
);

    localparam int RW       = rrip_pkg::RRPV_W;
    localparam int MASKED   = (NUM_WAYS < rrip_pkg::MASK_W) ? NUM_WAYS : rrip_pkg::MASK_W;
    localparam int WAY_CMPW = rrip_pkg::WAY_W + 2;

    logic [RW-1:0]                top;
    logic [RW-1:0]                lift;
    logic [RW-1:0]                ins;
    logic                         any_hi;
    logic                         any_lo;
    logic                         found_inv;
    logic                         found_top;
    logic [rrip_pkg::WAY_W-1:0]   inv_way;
    logic [rrip_pkg::WAY_W-1:0]   top_way;
    logic                         way_ok;

    always_comb
    begin
        any_hi = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            any_hi = any_hi | row_in[w*RW+1];
        end
        any_lo = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            any_lo = any_lo | (row_in[w*RW] & (row_in[w*RW+1] == any_hi));
        end
        top  = {any_hi, any_lo};
        lift = rrip_pkg::RRPV_MAX - top;

        found_inv = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < MASKED; w++)
        begin
            if (!found_inv && !req.mask[w])
            begin
                found_inv = 1'b1;
                inv_way   = rrip_pkg::WAY_W'(w);
            end
        end

        found_top = 1'b0;
        top_way   = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (!found_top && (row_in[w*RW +: RW] == top))
            begin
                found_top = 1'b1;
                top_way   = rrip_pkg::WAY_W'(w);
            end
        end

        victim = found_inv ? inv_way : top_way;
    end

    always_comb
    begin
        way_ok = (WAY_CMPW'(req.way) < WAY_CMPW'(NUM_WAYS));

        priority if (req.first)
        begin
            ins = rrip_pkg::RRPV_NEAR;
        end
        else if (!req.second && (duel_in >= rrip_pkg::DUEL_MID))
        begin
            ins = rrip_pkg::RRPV_NEAR;
        end
        else
        begin
            ins = req.chance_zero ? rrip_pkg::RRPV_NEAR : rrip_pkg::RRPV_MAX;
        end

        row_out  = row_in;
        duel_out = duel_in;

        if (req.req_type == rrip_pkg::REQ_VICTIM)
        begin
            if (!found_inv)
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    row_out[w*RW +: RW] = row_in[w*RW +: RW] + lift;
                end
            end
        end
        else
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                if ((w < (1 << rrip_pkg::WAY_W)) && (WAY_CMPW'(req.way) == WAY_CMPW'(w)))
                begin
                    row_out[w*RW +: RW] = req.is_hit ? rrip_pkg::RRPV_ZERO : ins;
                end
            end
            if (req.is_hit && way_ok)
            begin
                if (req.first && (duel_in < rrip_pkg::DUEL_TOP))
                begin
                    duel_out = duel_in + 1'b1;
                end
                else if (req.second && (duel_in > rrip_pkg::DUEL_ZERO))
                begin
                    duel_out = duel_in - 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/rrip_set_dueling_replacement.sv
// Channel   Handshake        Beat
// -------   --------------   ----------------------------------------------------
// request   start / busy     req_type, set_index, way_valid_mask, way_index,
//                            is_hit, chance
// result    done             victim_way, followers_use_srrip
//
// Each request reads the set row from the single-port memory and then
// modifies it and writes it back, so busy is high for one cycle after each
// accepted beat. A victim query drives done for one cycle, in the cycle after
// its write-back. After reset, busy stays high while the memory is cleared.
// The receiver cannot stall, so results never hold up the next request.
module rrip_set_dueling_replacement #(
    parameter int NUM_SETS    = rrip_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS    = rrip_pkg::DEF_NUM_WAYS,
    parameter int LEADER_SETS = rrip_pkg::DEF_LEADER_SETS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            req_type,
    input  logic [rrip_pkg::SET_IN_W-1:0]   set_index,
    input  logic [rrip_pkg::MASK_W-1:0]     way_valid_mask,
    input  logic [rrip_pkg::WAY_W-1:0]      way_index,
    input  logic                            is_hit,
    input  logic [rrip_pkg::CHANCE_W-1:0]   chance,
    output logic                            done,
    output logic [rrip_pkg::WAY_W-1:0]      victim_way,
    output logic                            followers_use_srrip
);

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int ROW_W = NUM_WAYS * rrip_pkg::RRPV_W;
    localparam int REM_W = rrip_pkg::REM_W;

    localparam logic [REM_W-1:0] SETS_R     = REM_W'(NUM_SETS);
    localparam logic [REM_W-1:0] LEAD_R     = REM_W'(LEADER_SETS);
    localparam logic [REM_W-1:0] HALF_R     = REM_W'(NUM_SETS / 2);
    localparam logic [REM_W-1:0] HALF_END_R = REM_W'(NUM_SETS / 2 + LEADER_SETS);
    localparam logic [SET_W-1:0] LAST_SET   = SET_W'(NUM_SETS - 1);

    rrip_pkg::rrip_state_t state_reg, state_next;
    logic [SET_W-1:0]               clr_reg, clr_next;
    logic [rrip_pkg::DUEL_W-1:0]    duel_reg, duel_next;
    logic                           done_reg, done_next;
    rrip_pkg::rrip_req_t            req_reg;
    logic [SET_W-1:0]               set_reg;
    logic [rrip_pkg::WAY_W-1:0]     victim_reg;
    logic                           srrip_reg;

    logic [REM_W-1:0]               rem;
    rrip_pkg::rrip_req_t            req_in;
    logic                           accept;
    logic                           mem_en;
    logic                           mem_we;
    logic [SET_W-1:0]               mem_addr;
    logic [ROW_W-1:0]               mem_wdata;
    logic [ROW_W-1:0]               mem_rdata;
    logic [ROW_W-1:0]               row_new;
    logic [rrip_pkg::WAY_W-1:0]     victim_new;
    logic [rrip_pkg::DUEL_W-1:0]    duel_new;

    always_comb
    begin
        rem = REM_W'(set_index);
        for (int k = 2; k >= 0; k--)
        begin
            if (rem >= (SETS_R << k))
            begin
                rem = rem - (SETS_R << k);
            end
        end

        req_in.req_type    = req_type;
        req_in.mask        = way_valid_mask;
        req_in.way         = way_index;
        req_in.is_hit      = is_hit;
        req_in.chance_zero = (chance == '0);
        req_in.first       = (rem < LEAD_R);
        req_in.second      = (rem >= HALF_R) && (rem < HALF_END_R);
    end

    assign busy   = (state_reg != rrip_pkg::ST_IDLE);
    assign accept = start && (state_reg == rrip_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        duel_next  = duel_reg;
        done_next  = 1'b0;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = rem[SET_W-1:0];
        mem_wdata  = '0;

        unique case (state_reg)
            rrip_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_SET)
                begin
                    state_next = rrip_pkg::ST_IDLE;
                end
            end
            rrip_pkg::ST_IDLE:
            begin
                mem_en = accept;
                if (accept)
                begin
                    state_next = rrip_pkg::ST_MODIFY;
                end
            end
            rrip_pkg::ST_MODIFY:
            begin
                mem_we     = 1'b1;
                mem_addr   = set_reg;
                mem_wdata  = row_new;
                duel_next  = duel_new;
                done_next  = (req_reg.req_type == rrip_pkg::REQ_VICTIM);
                state_next = rrip_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rrip_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrip_pkg::ST_CLEAR;
            clr_reg   <= '0;
            duel_reg  <= rrip_pkg::DUEL_MID;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            duel_reg  <= duel_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_in;
            set_reg <= rem[SET_W-1:0];
        end
        if (state_reg == rrip_pkg::ST_MODIFY)
        begin
            victim_reg <= victim_new;
            srrip_reg  <= (duel_reg >= rrip_pkg::DUEL_MID);
        end
    end

    rrip_row_mem #(
        .DEPTH  (NUM_SETS),
        .ROW_W  (ROW_W),
        .ADDR_W (SET_W)
    ) u_row_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    rrip_row_logic #(
        .NUM_WAYS (NUM_WAYS)
    ) u_row_logic (
        .req      (req_reg),
        .row_in   (mem_rdata),
        .duel_in  (duel_reg),
        .row_out  (row_new),
        .victim   (victim_new),
        .duel_out (duel_new)
    );

    assign done                = done_reg;
    assign victim_way          = victim_reg;
    assign followers_use_srrip = srrip_reg;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int NUM_SETS    = rrip_pkg::DEF_NUM_SETS;
    localparam int NUM_WAYS    = rrip_pkg::DEF_NUM_WAYS;
    localparam int LEADER_SETS = rrip_pkg::DEF_LEADER_SETS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HIT_BIAS    = 97;

    localparam int SET_IN_W = rrip_pkg::SET_IN_W;
    localparam int MASK_W   = rrip_pkg::MASK_W;
    localparam int WAY_W    = rrip_pkg::WAY_W;
    localparam int CHANCE_W = rrip_pkg::CHANCE_W;
    localparam int DUEL_W   = rrip_pkg::DUEL_W;
    localparam int RRPV_W   = rrip_pkg::RRPV_W;

    localparam logic [RRPV_W-1:0] RRPV_ZERO = rrip_pkg::RRPV_ZERO;
    localparam logic [RRPV_W-1:0] RRPV_NEAR = rrip_pkg::RRPV_NEAR;
    localparam logic [RRPV_W-1:0] RRPV_MAX  = rrip_pkg::RRPV_MAX;

    localparam logic [DUEL_W-1:0] DUEL_ZERO = rrip_pkg::DUEL_ZERO;
    localparam logic [DUEL_W-1:0] DUEL_MID  = rrip_pkg::DUEL_MID;
    localparam logic [DUEL_W-1:0] DUEL_TOP  = rrip_pkg::DUEL_TOP;

    localparam logic REQ_VICTIM = rrip_pkg::REQ_VICTIM;
    localparam logic REQ_UPDATE = rrip_pkg::REQ_UPDATE;

    localparam int SET_POOL [10] = '{0, 1, 63, 64, 1023, 1024, 1030, 1087, 1088, 2047};

    typedef enum int {
        BIAS_NONE,
        BIAS_FIRST,
        BIAS_SECOND
    } hit_bias_t;

    typedef struct {
        logic [WAY_W-1:0] way;
        logic             srrip;
    } victim_beat_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                req_type;
    logic [SET_IN_W-1:0] set_index;
    logic [MASK_W-1:0]   way_valid_mask;
    logic [WAY_W-1:0]    way_index;
    logic                is_hit;
    logic [CHANCE_W-1:0] chance;
    logic                done;
    logic [WAY_W-1:0]    victim_way;
    logic                followers_use_srrip;

    logic [RRPV_W-1:0] rrpv_model [NUM_SETS][NUM_WAYS];
    logic [DUEL_W-1:0] duel_model;
    victim_beat_t      victim_expect [$];

    int  error_count;
    int  cycle_count;
    bit  idle_en;

    rrip_set_dueling_replacement uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .req_type            (req_type),
        .set_index           (set_index),
        .way_valid_mask      (way_valid_mask),
        .way_index           (way_index),
        .is_hit              (is_hit),
        .chance              (chance),
        .done                (done),
        .victim_way          (victim_way),
        .followers_use_srrip (followers_use_srrip)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rrip_set_dueling_replacement test failed");
            $finish;
        end
    end

    task automatic predict_request(
        input logic                rt,
        input logic [SET_IN_W-1:0] si,
        input logic [MASK_W-1:0]   m,
        input logic [WAY_W-1:0]    wi,
        input logic                h,
        input logic [CHANCE_W-1:0] ch
    );
        int                s;
        int                w;
        bit                first;
        bit                second;
        bit                found;
        logic [RRPV_W-1:0] top;
        logic [RRPV_W-1:0] lift;
        logic [RRPV_W-1:0] ins;
        victim_beat_t      beat;
        s = int'(si) % NUM_SETS;
        first = s < LEADER_SETS;
        second = s >= NUM_SETS / 2 && s < NUM_SETS / 2 + LEADER_SETS;
        if (rt == REQ_VICTIM)
        begin
            found = 1'b0;
            beat.way = '0;
            for (w = 0; w < NUM_WAYS && w < MASK_W; w++)
            begin
                if (!found && !m[w])
                begin
                    found = 1'b1;
                    beat.way = WAY_W'(w);
                end
            end
            if (!found)
            begin
                top = RRPV_ZERO;
                for (w = 0; w < NUM_WAYS; w++)
                    if (rrpv_model[s][w] > top)
                        top = rrpv_model[s][w];
                lift = RRPV_MAX - top;
                for (w = 0; w < NUM_WAYS; w++)
                    rrpv_model[s][w] = rrpv_model[s][w] + lift;
                for (w = NUM_WAYS - 1; w >= 0; w--)
                    if (rrpv_model[s][w] == RRPV_MAX)
                        beat.way = WAY_W'(w);
            end
            beat.srrip = duel_model >= DUEL_MID;
            victim_expect = {victim_expect, beat};
        end
        else if (int'(wi) < NUM_WAYS)
        begin
            if (h)
            begin
                rrpv_model[s][wi] = RRPV_ZERO;
                if (first && duel_model < DUEL_TOP)
                    duel_model = duel_model + 1'b1;
                if (second && duel_model > DUEL_ZERO)
                    duel_model = duel_model - 1'b1;
            end
            else
            begin
                if (first || (!second && duel_model >= DUEL_MID))
                    ins = RRPV_NEAR;
                else
                    ins = (ch == '0) ? RRPV_NEAR : RRPV_MAX;
                rrpv_model[s][wi] = ins;
            end
        end
    endtask

    task automatic send_beat(
        input logic                rt,
        input logic [SET_IN_W-1:0] si,
        input logic [MASK_W-1:0]   m,
        input logic [WAY_W-1:0]    wi,
        input logic                h,
        input logic [CHANCE_W-1:0] ch
    );
        start          <= 1'b1;
        req_type       <= rt;
        set_index      <= si;
        way_valid_mask <= m;
        way_index      <= wi;
        is_hit         <= h;
        chance         <= ch;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predict_request(rt, si, m, wi, h, ch);
        if (idle_en && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic send_random(input hit_bias_t bias);
        int                  r;
        logic [SET_IN_W-1:0] si;
        logic [MASK_W-1:0]   m;
        r = $urandom_range(99);
        if (bias != BIAS_NONE && r < HIT_BIAS)
        begin
            si = SET_IN_W'($urandom_range(LEADER_SETS - 1));
            if (bias == BIAS_SECOND)
                si = si + SET_IN_W'(NUM_SETS / 2);
            send_beat(REQ_UPDATE, si, MASK_W'($urandom), WAY_W'($urandom), 1'b1,
                      CHANCE_W'($urandom));
        end
        else
        begin
            if ($urandom_range(9) == 0)
                si = SET_IN_W'($urandom_range(NUM_SETS - 1));
            else
                si = SET_IN_W'(SET_POOL[$urandom_range(9)]);
            r = $urandom_range(99);
            if (r < 65)
                m = '1;
            else if (r < 85)
                m = ~(MASK_W'(1) << $urandom_range(MASK_W - 1));
            else
                m = MASK_W'($urandom);
            if ($urandom_range(99) < 45)
                send_beat(REQ_VICTIM, si, m, WAY_W'($urandom), 1'($urandom),
                          CHANCE_W'($urandom));
            else
                send_beat(REQ_UPDATE, si, m, WAY_W'($urandom), 1'($urandom),
                          ($urandom_range(3) == 0) ? '0 : CHANCE_W'($urandom));
        end
    endtask

    task automatic wait_results_drained;
        start <= 1'b0;
        @(posedge clk);
        while (victim_expect.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed;
        send_beat(REQ_VICTIM, 11'd0, 16'h0000, 4'd0, 1'b0, 5'd0);
        send_beat(REQ_VICTIM, 11'd0, 16'hFFFE, 4'd0, 1'b0, 5'd0);
        send_beat(REQ_VICTIM, 11'd0, 16'h7FFF, 4'd0, 1'b0, 5'd0);
        send_beat(REQ_VICTIM, 11'd2047, 16'hFFFF, 4'd0, 1'b0, 5'd0);
        send_beat(REQ_UPDATE, 11'd2047, 16'h0000, 4'd0, 1'b1, 5'd31);
        send_beat(REQ_UPDATE, 11'd2047, 16'hFFFF, 4'd15, 1'b0, 5'd31);
        send_beat(REQ_VICTIM, 11'd2047, 16'hFFFF, 4'd15, 1'b1, 5'd31);
        send_beat(REQ_UPDATE, 11'd0, 16'h0000, 4'd3, 1'b0, 5'd31);
        send_beat(REQ_UPDATE, 11'd0, 16'h0000, 4'd5, 1'b1, 5'd0);
        send_beat(REQ_VICTIM, 11'd100, 16'hFFFF, 4'd0, 1'b0, 5'd0);
        send_beat(REQ_UPDATE, 11'd1024, 16'h0000, 4'd2, 1'b1, 5'd0);
        send_beat(REQ_UPDATE, 11'd1087, 16'h0000, 4'd2, 1'b1, 5'd0);
        send_beat(REQ_UPDATE, 11'd100, 16'h0000, 4'd0, 1'b0, 5'd31);
        send_beat(REQ_UPDATE, 11'd100, 16'h0000, 4'd1, 1'b0, 5'd0);
        send_beat(REQ_UPDATE, 11'd1024, 16'h0000, 4'd4, 1'b0, 5'd0);
        send_beat(REQ_UPDATE, 11'd1024, 16'h0000, 4'd5, 1'b0, 5'd31);
        send_beat(REQ_VICTIM, 11'd100, 16'hFFFF, 4'd0, 1'b0, 5'd0);
        send_beat(REQ_VICTIM, 11'd1024, 16'hFFFF, 4'd0, 1'b0, 5'd0);
        send_beat(REQ_UPDATE, 11'd63, 16'h0000, 4'd15, 1'b1, 5'd0);
        send_beat(REQ_UPDATE, 11'd64, 16'h0000, 4'd7, 1'b1, 5'd0);
        send_beat(REQ_UPDATE, 11'd1088, 16'h0000, 4'd7, 1'b1, 5'd0);
        send_beat(REQ_VICTIM, 11'd1023, 16'hFFFF, 4'd0, 1'b0, 5'd0);
        send_beat(REQ_VICTIM, 11'd0, 16'hFFFF, 4'd0, 1'b0, 5'd0);
    endtask

    // Second leader group hits dominate, so the duel counter falls to zero.
    task automatic test_duel_low;
        repeat (540)
            send_random(BIAS_SECOND);
    endtask

    // First leader group hits dominate, so the duel counter climbs to its top.
    task automatic test_duel_high;
        repeat (1100)
            send_random(BIAS_FIRST);
    endtask

    task automatic test_mixed;
        repeat (120)
            send_random(BIAS_NONE);
    endtask

    task automatic test_back_to_back;
        idle_en = 1'b0;
        repeat (100)
            send_random(BIAS_NONE);
    endtask

    always @(posedge clk)
    begin
        victim_beat_t beat;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (victim_expect.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result beat: victim_way=%0d followers_use_srrip=%0b",
                             victim_way, followers_use_srrip);
            end
            else
            begin
                beat = victim_expect.pop_front();
                if (victim_way !== beat.way || followers_use_srrip !== beat.srrip)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch: victim_way exp %0d got %0d, %s %0b got %0b",
                                 beat.way, victim_way, "followers_use_srrip exp",
                                 beat.srrip, followers_use_srrip);
                end
            end
        end
    end

    initial
    begin
        int s;
        int w;
        idle_en        = 1'b1;
        duel_model     = DUEL_MID;
        for (s = 0; s < NUM_SETS; s++)
            for (w = 0; w < NUM_WAYS; w++)
                rrpv_model[s][w] = RRPV_ZERO;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        req_type       <= REQ_VICTIM;
        set_index      <= '0;
        way_valid_mask <= '0;
        way_index      <= '0;
        is_hit         <= 1'b0;
        chance         <= '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed;
        wait_results_drained;
        test_duel_low;
        wait_results_drained;
        test_duel_high;
        test_mixed;
        test_back_to_back;

        wait_results_drained;
        repeat (8)
            @(posedge clk);
        if (error_count == 0 && victim_expect.size() == 0)
            $display("rrip_set_dueling_replacement test passed");
        else
            $display("rrip_set_dueling_replacement test failed");
        $finish;
    end

endmodule
